/* sv/tapid_pkg.sv */
// Package for the three-axis PID block: widths, register indexes, commands.
// No dependencies; every other file imports it.
package tapid_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int GAIN_FRAC_BITS  = 12;
  localparam int COEF_BITS       = 16;
  localparam int ERR_W           = 15;
  localparam int GAIN_W          = 48;
  localparam int REG16_W         = 16;
  localparam int IDX_W           = 3;
  localparam int ACC_W           = 72;
  localparam int MUL_W           = 25;
  localparam int MULB_W          = 17;

  localparam logic [IDX_W-1:0] REG_PITCH_GAINS = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROLL_GAINS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_YAW_GAINS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_LIMIT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_PITCH_RATE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROLL_RATE   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DERIV_COEF  = 3'd6;
  localparam logic [IDX_W-1:0] REG_OUT_COEF    = 3'd7;

  localparam logic [GAIN_W-1:0] YAW_GAINS_RESET = 48'd225180867888965;

  // Datapath micro-operations, one per controller step.
  typedef enum logic [3:0] {
    OP_LOAD   = 4'd0,  // latch errors of the beat
    OP_INT    = 4'd1,  // e*ki, integrate and clamp
    OP_DIFF   = 4'd2,  // c*(diff - D)
    OP_DSAT   = 4'd3,  // saturate D, start D*kd
    OP_DK     = 4'd4,  // (D*kd)*100
    OP_EKP    = 4'd5,  // e*kp
    OP_EKPS   = 4'd6,  // (e*kp)*scale, form sum
    OP_SLEW   = 4'd7,  // clamp sum, slew limit, f*r
    OP_SMOOTH = 4'd8,  // update smoothed output
    OP_OUT    = 4'd9   // assemble result
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } dp_cmd_t;

endpackage

/* sv/tapid_if.sv */
// Valid/ready channel interfaces for the three-axis PID block.
// Depends on tapid_pkg for field widths.
interface tapid_in_if import tapid_pkg::*; (input logic clk);
  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] pitch_error;
  logic signed [ERR_W-1:0] roll_error;
  logic signed [ERR_W-1:0] yaw_error;
  modport source (output valid, pitch_error, roll_error, yaw_error, input ready);
  modport sink   (input valid, pitch_error, roll_error, yaw_error, output ready);
endinterface

interface tapid_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [16:0] pitch_drive;
  logic signed [16:0] roll_drive;
  logic        [15:0] yaw_drive;
  modport source (output valid, pitch_drive, roll_drive, yaw_drive, input ready);
  modport sink   (input valid, pitch_drive, roll_drive, yaw_drive, output ready);
endinterface

interface tapid_cfg_if import tapid_pkg::*; (input logic clk);
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [GAIN_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tapid_ctrl.sv */
// Sequencer for the three-axis PID block: steps each axis through the datapath.
// Depends on tapid_pkg.
module tapid_ctrl import tapid_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    cmd_en,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign cmd.op    = (state_r == S_IDLE) ? OP_LOAD : op_r;
  assign cmd.axis  = axis_r;
  assign cmd_en    = (state_r == S_IDLE) ? in_valid
                   : (state_r == S_RUN) ? !(op_r == OP_OUT && ovalid_r) : 1'b0;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    axis_nxt   = axis_r;
    ovalid_nxt = ovalid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
          op_nxt    = OP_INT;
          axis_nxt  = 2'd0;
        end
      end
      S_RUN: begin
        case (op_r)
          OP_INT:    op_nxt = OP_DIFF;
          OP_DIFF:   op_nxt = OP_DSAT;
          OP_DSAT:   op_nxt = OP_DK;
          OP_DK:     op_nxt = OP_EKP;
          OP_EKP:    op_nxt = OP_EKPS;
          OP_EKPS:   op_nxt = (axis_r == 2'd2) ? OP_OUT : OP_SLEW;
          OP_SLEW:   op_nxt = OP_SMOOTH;
          OP_SMOOTH: begin
            op_nxt   = OP_INT;
            axis_nxt = axis_r + 2'd1;
          end
          OP_OUT: begin
            if (!ovalid_r) begin
              ovalid_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          default:   op_nxt = OP_INT;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      op_r     <= OP_INT;
      axis_r   <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      axis_r   <= axis_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_RUN && axis_r == 2'd0)
    else $error("accept did not start axis 0");
  a_axis: assert property (@(posedge clk) disable iff (!rst_n) axis_r != 2'd3)
    else $error("axis out of range");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN && $past(state_r) == S_RUN && state_nxt == S_IDLE |=> out_valid)
    else $error("finished item without result");

endmodule

/* sv/tapid_dp.sv */
// Datapath for the three-axis PID block: register file, state and shared multiplier.
// Depends on tapid_pkg; commanded by tapid_ctrl.
module tapid_dp import tapid_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [GAIN_W-1:0]  cfg_data,
  input  logic               cmd_en,
  input  dp_cmd_t            cmd,
  input  logic signed [ERR_W-1:0] in_pitch,
  input  logic signed [ERR_W-1:0] in_roll,
  input  logic signed [ERR_W-1:0] in_yaw,
  output logic signed [16:0] pitch_drive,
  output logic signed [16:0] roll_drive,
  output logic        [15:0] yaw_drive
);

  localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) <<< GAIN_FRAC_BITS;

  logic [GAIN_W-1:0]  gains_r [3];
  logic [REG16_W-1:0] lim_r, prate_r, rrate_r, dcoef_r, ocoef_r;

  logic signed [23:0] integ_r [3];
  logic signed [15:0] prev_r  [3];
  logic signed [23:0] deriv_r [3];
  logic signed [17:0] smooth_r [2];

  logic signed [15:0] err_r [3];
  logic signed [ACC_W-1:0] prod_r, sum_r;
  logic signed [16:0] pd_r, rd_r;
  logic        [15:0] yd_r;

  // One shared 25 x 17 bit signed multiplier; constant scales use shifts and adds.
  logic signed [MUL_W-1:0]        mul_a;
  logic signed [MULB_W-1:0]       mul_b;
  logic signed [MUL_W+MULB_W-1:0] mul_w;
  logic signed [ACC_W-1:0]        mul_p;
  assign mul_w = mul_a * mul_b;
  assign mul_p = ACC_W'(mul_w);

  logic [1:0] ax;
  logic signed [ACC_W-1:0] e, kp, ki, kd, ilo, ihi, ylo, yhi, sm, rate, t, r;
  logic signed [ACC_W-1:0] prod_sat, dk100, pks;
  assign ax = cmd.axis;

  function automatic logic signed [ACC_W-1:0] clampv(
    input logic signed [ACC_W-1:0] v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  always_comb begin
    e    = ACC_W'(err_r[ax]);
    kp   = ACC_W'({1'b0, gains_r[ax][15:0]});
    ki   = ACC_W'({1'b0, gains_r[ax][31:16]});
    kd   = ACC_W'({1'b0, gains_r[ax][47:32]});
    ilo  = (ax == 2'd2) ? '0 : -(ONE * 8);
    ihi  = (ax == 2'd2) ? ONE * 200 : ONE * 8;
    ylo  = (ax == 2'd2) ? '0 : -ACC_W'({1'b0, lim_r});
    yhi  = (ax == 2'd2) ? ONE * 1000 : ACC_W'({1'b0, lim_r});
    sm   = ACC_W'(smooth_r[ax[0]]);
    rate = ACC_W'({1'b0, ax[0] ? rrate_r : prate_r});
    t    = clampv(sum_r, ylo, yhi);
    r    = clampv(t - sm, -rate, rate);
    prod_sat = clampv(prod_r >>> COEF_BITS, -ACC_W'(8388608), ACC_W'(8388607));
    // x*100 = 64x + 32x + 4x; x*20 = 16x + 4x; x*10 = 8x + 2x
    dk100 = (prod_r <<< 6) + (prod_r <<< 5) + (prod_r <<< 2);
    pks   = (ax == 2'd2) ? (prod_r <<< 4) + (prod_r <<< 2)
                         : (prod_r <<< 3) + (prod_r <<< 1);
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_INT:  begin mul_a = MUL_W'(e); mul_b = MULB_W'(ki); end
      OP_DIFF: begin
        mul_a = MUL_W'(((e - ACC_W'(prev_r[ax])) <<< (GAIN_FRAC_BITS - ANGLE_FRAC_BITS))
                - ACC_W'(deriv_r[ax]));
        mul_b = MULB_W'({1'b0, dcoef_r});
      end
      OP_DSAT: begin mul_a = MUL_W'(prod_sat); mul_b = MULB_W'(kd); end
      OP_EKP:  begin mul_a = MUL_W'(e); mul_b = MULB_W'(kp); end
      OP_SLEW: begin mul_a = MUL_W'(r); mul_b = MULB_W'({1'b0, ocoef_r}); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r[0] <= '0;
      gains_r[1] <= '0;
      gains_r[2] <= YAW_GAINS_RESET;
      lim_r   <= 16'd16384;
      prate_r <= 16'd40960;
      rrate_r <= 16'd40960;
      dcoef_r <= 16'd32768;
      ocoef_r <= 16'd32768;
      for (int i = 0; i < 3; i++) begin
        integ_r[i] <= '0;
        prev_r[i]  <= '0;
        deriv_r[i] <= '0;
      end
      smooth_r[0] <= '0;
      smooth_r[1] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PITCH_GAINS: gains_r[0] <= cfg_data;
          REG_ROLL_GAINS:  gains_r[1] <= cfg_data;
          REG_YAW_GAINS:   gains_r[2] <= cfg_data;
          REG_OUT_LIMIT:   lim_r      <= cfg_data[15:0];
          REG_PITCH_RATE:  prate_r    <= cfg_data[15:0];
          REG_ROLL_RATE:   rrate_r    <= cfg_data[15:0];
          REG_DERIV_COEF:  dcoef_r    <= cfg_data[15:0];
          REG_OUT_COEF:    ocoef_r    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd_en) begin
        case (cmd.op)
          OP_INT:  integ_r[ax] <= 24'(clampv(ACC_W'(integ_r[ax]) + (mul_p >>> ANGLE_FRAC_BITS),
                                             ilo, ihi));
          OP_DSAT: deriv_r[ax] <= 24'(prod_sat);
          OP_EKPS: prev_r[ax]  <= 16'(e);
          OP_SMOOTH: smooth_r[ax[0]] <= 18'(clampv(sm + (prod_r >>> COEF_BITS),
                                                   -ACC_W'(131072), ACC_W'(131071)));
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r <= '0;
      rd_r <= '0;
      yd_r <= '0;
    end else if (cmd_en) begin
      prod_r <= mul_p;
      case (cmd.op)
        OP_LOAD: begin
          err_r[0] <= 16'(in_pitch);
          err_r[1] <= 16'(in_roll);
          err_r[2] <= -16'(in_yaw);
        end
        OP_DK:   sum_r <= (dk100 >>> GAIN_FRAC_BITS) + ACC_W'(integ_r[ax]);
        OP_EKPS: sum_r <= sum_r + (pks >>> ANGLE_FRAC_BITS);
        OP_OUT: begin
          pd_r  <= 17'(clampv(ACC_W'(smooth_r[0]), -ACC_W'(65536), ACC_W'(65535)));
          rd_r  <= 17'(clampv(-ACC_W'(smooth_r[1]), -ACC_W'(65536), ACC_W'(65535)));
          yd_r  <= 16'(clampv(t >>> (GAIN_FRAC_BITS - ANGLE_FRAC_BITS), '0,
                              ACC_W'(65535)));
        end
        default: ;
      endcase
    end
  end

  assign pitch_drive = pd_r;
  assign roll_drive  = rd_r;
  assign yaw_drive   = yd_r;

  a_yaw_int: assert property (@(posedge clk) disable iff (!rst_n)
    integ_r[2] >= 0 && integ_r[2] <= 24'sd819200) else $error("yaw integral out of range");
  a_pr_int: assert property (@(posedge clk) disable iff (!rst_n)
    integ_r[0] >= -24'sd32768 && integ_r[0] <= 24'sd32768) else $error("pitch integral");
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_we) |-> $stable(lim_r)) else $error("limit changed without write");
  a_yaw_le: assert property (@(posedge clk) disable iff (!rst_n)
    yd_r <= 16'd64000) else $error("yaw drive above limit");

endmodule

/* sv/three_axis_pid_slew_limited.sv */
// Top level of the three-axis PID block with slew limiting.
// Depends on tapid_pkg, tapid_if, tapid_ctrl and tapid_dp.
//
//   channel | direction | payload
//   in_     | sink      | pitch_error, roll_error, yaw_error (15b signed)
//   out_    | source    | pitch_drive, roll_drive (17b signed), yaw_drive (16b)
//   cfg_    | sink      | index (3b), data (48b)
//
// From accept to result, one shared multiplier walks eight steps for pitch and
// roll and six for yaw, plus a load step and a result step.
// Reset (synchronous, rst_n low) loads register defaults; clears axis and FSM state.
// A held result stalls the next item only at its result step; cfg is always ready.
module three_axis_pid_slew_limited import tapid_pkg::*; (
  input logic clk,
  input logic rst_n,
  tapid_in_if.sink    in_ch,
  tapid_out_if.source out_ch,
  tapid_cfg_if.sink   cfg_ch
);

  logic    cmd_en;
  dp_cmd_t cmd;

  // Take configuration beats at any time.
  assign cfg_ch.ready = 1'b1;

  tapid_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd_en,
    .cmd
  );

  tapid_dp u_dp (
    .clk,
    .rst_n,
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .cmd_en,
    .cmd,
    .in_pitch    (in_ch.pitch_error),
    .in_roll     (in_ch.roll_error),
    .in_yaw      (in_ch.yaw_error),
    .pitch_drive (out_ch.pitch_drive),
    .roll_drive  (out_ch.roll_drive),
    .yaw_drive   (out_ch.yaw_drive)
  );

endmodule
